// ----- design/ccs_pkg.sv -----
package ccs_pkg;

  localparam int unsigned CountW = 12;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CountW-1:0] NarrowLimitRst = 12'd77;
  localparam logic [CountW-1:0] WideLimitRst = 12'd232;

  localparam logic [CfgIdxW-1:0] CFG_NARROW = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_WIDE = 1'b1;

  typedef enum logic [2:0] {
    PH_FIRST   = 3'd0,
    PH_COMMON  = 3'd1,
    PH_CHGDIS  = 3'd2,
    PH_DONE    = 3'd3,
    PH_BLOCKED = 3'd4,
    PH_DISC    = 3'd5,
    PH_SHUT    = 3'd6
  } phase_t;

  typedef struct packed {
    logic              current_valid;
    logic [CountW-1:0] current_counts;
    logic              common_closed;
    logic              charge_closed;
    logic              discharge_closed;
    logic              battery_in_range;
    logic              shutdown_request;
    logic              charge_allowed;
    logic              discharge_allowed;
    logic              charge_override;
    logic              discharge_override;
  } req_t;

  typedef struct packed {
    phase_t phase;
    phase_t phase_before_block;
    logic   charge_confirmed;
    logic   discharge_confirmed;
    logic   startup_done;
    logic   en_common;
    logic   en_charge;
    logic   en_discharge;
    logic   en_hv;
    logic   fault;
    logic   strobe;
    logic   forbid;
  } state_t;

  typedef struct packed {
    logic       common_enable;
    logic       charge_enable;
    logic       discharge_enable;
    logic       high_voltage_enable;
    logic       contactor_fault;
    logic       strobe_light;
    logic       charge_forbid;
    logic       clear_charge_override;
    logic       clear_discharge_override;
    logic       startup_complete;
    logic [2:0] phase_code;
  } res_t;

  typedef struct packed {
    logic [CountW-1:0] narrow;
    logic [CountW-1:0] wide;
  } limits_t;

endpackage

// ----- design/ccs_cfg.sv -----
module ccs_cfg
  import ccs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output limits_t             limits
);

  logic [CountW-1:0] narrow_r, narrow_nxt;
  logic [CountW-1:0] wide_r, wide_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    narrow_nxt = narrow_r;
    wide_nxt = wide_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_NARROW: narrow_nxt = cfg_data;
        CFG_WIDE:   wide_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      narrow_r <= NarrowLimitRst;
      wide_r <= WideLimitRst;
    end else begin
      narrow_r <= narrow_nxt;
      wide_r <= wide_nxt;
    end
  end

  assign limits.narrow = narrow_r;
  assign limits.wide = wide_r;

endmodule

// ----- design/ccs_step.sv -----
module ccs_step
  import ccs_pkg::*;
(
  input  req_t    req,
  input  state_t  st,
  input  limits_t limits,
  output state_t  st_nxt,
  output res_t    res
);

  logic   narrow_ok;
  logic   wide_ok;
  logic   err;
  logic   cc;
  logic   dc;
  logic   c_on;
  logic   d_on;
  logic   clr_c;
  logic   clr_d;
  logic   disc;
  phase_t ph;

  assign narrow_ok = req.current_valid && (req.current_counts <= limits.narrow);
  assign wide_ok = req.current_valid && (req.current_counts <= limits.wide);

  always_comb begin
    st_nxt = st;
    clr_c = 1'b0;
    clr_d = 1'b0;
    c_on = 1'b0;
    d_on = 1'b0;
    disc = 1'b0;
    err = 1'b0;
    cc = st.charge_confirmed;
    dc = st.discharge_confirmed;
    ph = st.phase;

    // block before evaluating while battery out of range and not started
    if (!req.battery_in_range && !st.startup_done) begin
      st_nxt.phase_before_block = st.phase;
      ph = PH_BLOCKED;
    end
    st_nxt.phase = ph;

    unique case (ph)
      PH_FIRST: begin
        err = !narrow_ok;
        st_nxt.fault = err;
        if (!err) begin
          st_nxt.en_common = 1'b1;
          st_nxt.phase = PH_COMMON;
        end
      end
      PH_COMMON: begin
        err = !(narrow_ok && req.common_closed);
        st_nxt.fault = err;
        if (!err) begin
          st_nxt.phase = PH_CHGDIS;
          st_nxt.en_charge = 1'b1;
          st_nxt.en_discharge = 1'b1;
        end
      end
      PH_CHGDIS: begin
        cc = st.charge_confirmed || (wide_ok && req.charge_closed);
        dc = st.discharge_confirmed || (wide_ok && req.discharge_closed);
        st_nxt.charge_confirmed = cc;
        st_nxt.discharge_confirmed = dc;
        err = !(cc && dc);
        st_nxt.fault = err;
        st_nxt.startup_done = st.startup_done || !err;
        if (st.startup_done || !err) begin
          st_nxt.en_hv = 1'b1;
          st_nxt.phase = PH_DONE;
        end
        disc = !req.common_closed || (cc && !req.charge_closed) ||
               (dc && !req.discharge_closed);
      end
      PH_DONE: begin
        if (req.shutdown_request) begin
          st_nxt.phase = PH_SHUT;
        end else begin
          if (!req.common_closed) begin
            disc = 1'b1;
          end else if (req.charge_allowed && req.charge_override &&
                       !req.charge_closed) begin
            clr_c = 1'b1;
            c_on = 1'b1;
            st_nxt.en_charge = 1'b1;
            st_nxt.phase = PH_CHGDIS;
          end else if (req.discharge_allowed && req.discharge_override &&
                       !req.discharge_closed) begin
            clr_d = 1'b1;
            d_on = 1'b1;
            st_nxt.en_discharge = 1'b1;
            st_nxt.phase = PH_CHGDIS;
          end
          if ((req.charge_allowed && !req.charge_closed && !c_on) ||
              (req.discharge_allowed && !req.discharge_closed && !d_on)) begin
            disc = 1'b1;
          end
        end
      end
      PH_BLOCKED: begin
        if (st_nxt.phase_before_block == PH_CHGDIS &&
            (!req.common_closed || (st.charge_confirmed && !req.charge_closed) ||
             (st.discharge_confirmed && !req.discharge_closed))) begin
          disc = 1'b1;
        end else if (req.battery_in_range) begin
          clr_c = 1'b1;
          clr_d = 1'b1;
          st_nxt.phase = PH_FIRST;
        end
      end
      PH_DISC, PH_SHUT: ;
      default: st_nxt.phase = PH_FIRST;
    endcase

    if (disc) begin
      st_nxt.en_common = 1'b0;
      st_nxt.en_charge = 1'b0;
      st_nxt.en_discharge = 1'b0;
      st_nxt.en_hv = 1'b0;
      st_nxt.fault = 1'b1;
      st_nxt.strobe = 1'b1;
      st_nxt.forbid = 1'b1;
      st_nxt.phase = PH_DISC;
    end
  end

  always_comb begin
    res.common_enable = st_nxt.en_common;
    res.charge_enable = st_nxt.en_charge;
    res.discharge_enable = st_nxt.en_discharge;
    res.high_voltage_enable = st_nxt.en_hv;
    res.contactor_fault = st_nxt.fault;
    res.strobe_light = st_nxt.strobe;
    res.charge_forbid = st_nxt.forbid;
    res.clear_charge_override = clr_c;
    res.clear_discharge_override = clr_d;
    res.startup_complete = st_nxt.startup_done;
    res.phase_code = st_nxt.phase;
  end

endmodule

// ----- design/contactor_close_sequencer.sv -----
// contactor close sequencer: one request per tick
// input channel (in_valid/in_ready) carries one tick of current reading,
// contactor sense levels and battery manager status; the result channel
// (out_valid/out_ready) returns the contactor drive levels, fault flags,
// override clear pulses and the phase code after that tick
// cfg channel writes the two current limits (index 0 narrow, 1 wide);
// always ready, write only while no request is in flight
// a request taken into the input register is evaluated against the sequencer
// state, and its result is loaded into the result register and marked valid
// throughput: one request per clock while results are taken, set by the
// single evaluate stage between the input register and the result register
// reset (rst_n low, synchronous): phase back to first check, all enables,
// confirms and fault flags cleared, limits back to 77 and 232
// a stalled receiver holds the result; one more request is taken into
// the input register, then in_ready drops until the result is taken
module contactor_close_sequencer
  import ccs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_current_valid,
  input  logic [CountW-1:0]   in_current_counts,
  input  logic                in_common_closed,
  input  logic                in_charge_closed,
  input  logic                in_discharge_closed,
  input  logic                in_battery_in_range,
  input  logic                in_shutdown_request,
  input  logic                in_charge_allowed,
  input  logic                in_discharge_allowed,
  input  logic                in_charge_override,
  input  logic                in_discharge_override,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_common_enable,
  output logic                out_charge_enable,
  output logic                out_discharge_enable,
  output logic                out_high_voltage_enable,
  output logic                out_contactor_fault,
  output logic                out_strobe_light,
  output logic                out_charge_forbid,
  output logic                out_clear_charge_override,
  output logic                out_clear_discharge_override,
  output logic                out_startup_complete,
  output logic [2:0]          out_phase_code,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  limits_t limits;
  req_t    req_r;
  logic    req_valid_r;
  state_t  st_r;
  state_t  st_nxt;
  res_t    res_nxt;
  res_t    res_r;
  logic    out_valid_r;
  logic    advance;

  ccs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  ccs_step u_step (
    .req    (req_r),
    .st     (st_r),
    .limits (limits),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign advance = req_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !req_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_ready) begin
      req_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_r.current_valid <= in_current_valid;
      req_r.current_counts <= in_current_counts;
      req_r.common_closed <= in_common_closed;
      req_r.charge_closed <= in_charge_closed;
      req_r.discharge_closed <= in_discharge_closed;
      req_r.battery_in_range <= in_battery_in_range;
      req_r.shutdown_request <= in_shutdown_request;
      req_r.charge_allowed <= in_charge_allowed;
      req_r.discharge_allowed <= in_discharge_allowed;
      req_r.charge_override <= in_charge_override;
      req_r.discharge_override <= in_discharge_override;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '{phase: PH_FIRST, phase_before_block: PH_FIRST, default: 1'b0};
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_common_enable = res_r.common_enable;
  assign out_charge_enable = res_r.charge_enable;
  assign out_discharge_enable = res_r.discharge_enable;
  assign out_high_voltage_enable = res_r.high_voltage_enable;
  assign out_contactor_fault = res_r.contactor_fault;
  assign out_strobe_light = res_r.strobe_light;
  assign out_charge_forbid = res_r.charge_forbid;
  assign out_clear_charge_override = res_r.clear_charge_override;
  assign out_clear_discharge_override = res_r.clear_discharge_override;
  assign out_startup_complete = res_r.startup_complete;
  assign out_phase_code = res_r.phase_code;

`ifndef SYNTH
  a_disc_dead: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.phase == PH_DISC |->
      !st_r.en_common && !st_r.en_charge && !st_r.en_discharge && !st_r.en_hv &&
      st_r.fault && st_r.strobe && st_r.forbid)
    else $error("disconnected phase with drive or flags inconsistent");

  a_hv_needs_startup: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.en_hv |-> st_r.startup_done)
    else $error("high voltage enabled before startup done");

  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && out_valid_r && !out_ready |-> !in_ready)
    else $error("input taken while both stages are full and stalled");

  a_advance_shows: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("evaluated request not presented");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(advance) && $past(rst_n) |-> $stable(st_r))
    else $error("sequencer state changed without a request");
`endif

endmodule

// ----- tb/ccs_drive_checker.sv -----
`timescale 1ns / 100ps
module ccs_drive_checker
  import ccs_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  logic                in_current_valid,
  input  logic [CountW-1:0]   in_current_counts,
  input  logic                in_common_closed,
  input  logic                in_charge_closed,
  input  logic                in_discharge_closed,
  input  logic                in_battery_in_range,
  input  logic                in_shutdown_request,
  input  logic                in_charge_allowed,
  input  logic                in_discharge_allowed,
  input  logic                in_charge_override,
  input  logic                in_discharge_override,
  input  logic                out_valid,
  input  logic                out_ready,
  input  logic                out_common_enable,
  input  logic                out_charge_enable,
  input  logic                out_discharge_enable,
  input  logic                out_high_voltage_enable,
  input  logic                out_contactor_fault,
  input  logic                out_strobe_light,
  input  logic                out_charge_forbid,
  input  logic                out_clear_charge_override,
  input  logic                out_clear_discharge_override,
  input  logic                out_startup_complete,
  input  logic [2:0]          out_phase_code,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  mismatches,
  output int                  outstanding
);

  logic [CountW-1:0] lim_narrow;
  logic [CountW-1:0] lim_wide;
  phase_t ph;
  phase_t ph_saved;
  logic chg_conf;
  logic dis_conf;
  logic started;
  logic en_com;
  logic en_chg;
  logic en_dis;
  logic en_hv;
  logic flt;
  logic strobe;
  logic forbid;
  res_t drive_expected[$];

  function automatic logic contact_lost(input req_t r);
    return !r.common_closed || (chg_conf && !r.charge_closed) ||
           (dis_conf && !r.discharge_closed);
  endfunction

  task automatic trip_all();
    en_com = 1'b0;
    en_chg = 1'b0;
    en_dis = 1'b0;
    en_hv = 1'b0;
    flt = 1'b1;
    strobe = 1'b1;
    forbid = 1'b1;
    ph = PH_DISC;
  endtask

  task automatic step_sequence(input req_t r, output res_t o);
    logic narrow_ok;
    logic wide_ok;
    logic err;
    logic clr_c;
    logic clr_d;
    logic c_on;
    logic d_on;
    narrow_ok = r.current_valid && (r.current_counts <= lim_narrow);
    wide_ok = r.current_valid && (r.current_counts <= lim_wide);
    clr_c = 1'b0;
    clr_d = 1'b0;
    c_on = 1'b0;
    d_on = 1'b0;
    if (!r.battery_in_range && !started) begin
      ph_saved = ph;
      ph = PH_BLOCKED;
    end
    case (ph)
      PH_FIRST: begin
        err = !narrow_ok;
        flt = err;
        if (!err) begin
          en_com = 1'b1;
          ph = PH_COMMON;
        end
      end
      PH_COMMON: begin
        err = !(narrow_ok && r.common_closed);
        flt = err;
        if (!err) begin
          ph = PH_CHGDIS;
          en_chg = 1'b1;
          en_dis = 1'b1;
        end
      end
      PH_CHGDIS: begin
        if (!chg_conf) chg_conf = wide_ok && r.charge_closed;
        if (!dis_conf) dis_conf = wide_ok && r.discharge_closed;
        err = !(chg_conf && dis_conf);
        flt = err;
        if (!started) started = !err;
        if (started) begin
          en_hv = 1'b1;
          ph = PH_DONE;
        end
        if (contact_lost(r)) trip_all();
      end
      PH_DONE: begin
        if (r.shutdown_request) begin
          ph = PH_SHUT;
        end else begin
          if (!r.common_closed) begin
            trip_all();
          end else if (r.charge_allowed && r.charge_override && !r.charge_closed) begin
            clr_c = 1'b1;
            c_on = 1'b1;
            en_chg = 1'b1;
            ph = PH_CHGDIS;
          end else if (r.discharge_allowed && r.discharge_override &&
                       !r.discharge_closed) begin
            clr_d = 1'b1;
            d_on = 1'b1;
            en_dis = 1'b1;
            ph = PH_CHGDIS;
          end
          if ((r.charge_allowed && !r.charge_closed && !c_on) ||
              (r.discharge_allowed && !r.discharge_closed && !d_on)) trip_all();
        end
      end
      PH_BLOCKED: begin
        if (ph_saved == PH_CHGDIS && contact_lost(r)) begin
          trip_all();
        end else if (r.battery_in_range) begin
          clr_c = 1'b1;
          clr_d = 1'b1;
          ph = PH_FIRST;
        end
      end
      PH_DISC, PH_SHUT: begin
      end
      default: begin
        ph = PH_FIRST;
      end
    endcase
    o.common_enable = en_com;
    o.charge_enable = en_chg;
    o.discharge_enable = en_dis;
    o.high_voltage_enable = en_hv;
    o.contactor_fault = flt;
    o.strobe_light = strobe;
    o.charge_forbid = forbid;
    o.clear_charge_override = clr_c;
    o.clear_discharge_override = clr_d;
    o.startup_complete = started;
    o.phase_code = ph;
  endtask

  task automatic check_field(input string name, input logic [2:0] want,
                             input logic [2:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%s mismatch: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk) begin
    req_t tick;
    res_t want;
    res_t got;
    if (!rst_n) begin
      mismatches = 0;
      lim_narrow = NarrowLimitRst;
      lim_wide = WideLimitRst;
      ph = PH_FIRST;
      ph_saved = PH_FIRST;
      chg_conf = 1'b0;
      dis_conf = 1'b0;
      started = 1'b0;
      en_com = 1'b0;
      en_chg = 1'b0;
      en_dis = 1'b0;
      en_hv = 1'b0;
      flt = 1'b0;
      strobe = 1'b0;
      forbid = 1'b0;
      drive_expected.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_NARROW) lim_narrow = cfg_data;
        else lim_wide = cfg_data;
      end
      if (out_valid && out_ready) begin
        got = {out_common_enable, out_charge_enable, out_discharge_enable,
               out_high_voltage_enable, out_contactor_fault, out_strobe_light,
               out_charge_forbid, out_clear_charge_override,
               out_clear_discharge_override, out_startup_complete, out_phase_code};
        if (drive_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("result with no request pending: %h", got);
        end else begin
          want = drive_expected.pop_front();
          check_bit("common_enable", want.common_enable, got.common_enable);
          check_bit("charge_enable", want.charge_enable, got.charge_enable);
          check_bit("discharge_enable", want.discharge_enable, got.discharge_enable);
          check_bit("high_voltage_enable", want.high_voltage_enable,
                    got.high_voltage_enable);
          check_bit("contactor_fault", want.contactor_fault, got.contactor_fault);
          check_bit("strobe_light", want.strobe_light, got.strobe_light);
          check_bit("charge_forbid", want.charge_forbid, got.charge_forbid);
          check_bit("clear_charge_override", want.clear_charge_override,
                    got.clear_charge_override);
          check_bit("clear_discharge_override", want.clear_discharge_override,
                    got.clear_discharge_override);
          check_bit("startup_complete", want.startup_complete, got.startup_complete);
          check_field("phase_code", want.phase_code, got.phase_code);
        end
      end
      if (in_valid && in_ready) begin
        tick = {in_current_valid, in_current_counts, in_common_closed, in_charge_closed,
                in_discharge_closed, in_battery_in_range, in_shutdown_request,
                in_charge_allowed, in_discharge_allowed, in_charge_override,
                in_discharge_override};
        step_sequence(tick, want);
        drive_expected.push_back(want);
      end
    end
    outstanding = drive_expected.size();
  end

endmodule

// ----- tb/contactor_close_sequencer_test.sv -----
`timescale 1ns / 100ps
module contactor_close_sequencer_test;
  import ccs_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_SPARSE,
    RX_PATTERN
  } rx_mode_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_current_valid;
  logic [CountW-1:0]   in_current_counts;
  logic                in_common_closed;
  logic                in_charge_closed;
  logic                in_discharge_closed;
  logic                in_battery_in_range;
  logic                in_shutdown_request;
  logic                in_charge_allowed;
  logic                in_discharge_allowed;
  logic                in_charge_override;
  logic                in_discharge_override;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                out_common_enable;
  logic                out_charge_enable;
  logic                out_discharge_enable;
  logic                out_high_voltage_enable;
  logic                out_contactor_fault;
  logic                out_strobe_light;
  logic                out_charge_forbid;
  logic                out_clear_charge_override;
  logic                out_clear_discharge_override;
  logic                out_startup_complete;
  logic [2:0]          out_phase_code;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;
  int                  mismatches;
  int                  outstanding;

  int unsigned       cycles = 0;
  rx_mode_t          rx_mode = RX_OPEN;
  int                burst_left = 0;
  logic [CountW-1:0] narrow_lim = NarrowLimitRst;
  logic [CountW-1:0] wide_lim = WideLimitRst;

  contactor_close_sequencer DUT (.*);

  ccs_drive_checker watch (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (cycles % 97 == 0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= $urandom_range(0, 1) == 1;
      RX_SPARSE: out_ready <= $urandom_range(0, 3) == 0;
      default: out_ready <= (cycles % 16) < 11;
    endcase
  end

  // flags: common, charge, discharge, in_range, shutdown, allow_c, allow_d, ovr_c, ovr_d
  function automatic req_t tick_of(input logic valid, input logic [CountW-1:0] counts,
                                   input logic [8:0] flags);
    return {valid, counts, flags};
  endfunction

  function automatic logic [CountW-1:0] pick_counts();
    logic [CountW-1:0] lim;
    lim = ($urandom_range(0, 1) == 1) ? wide_lim : narrow_lim;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return lim;
      2: return (lim == '1) ? lim : lim + 1'b1;
      3: return '1;
      4, 5: return CountW'($urandom_range(0, lim));
      default: return CountW'($urandom_range(0, 4095));
    endcase
  endfunction

  function automatic req_t noise_tick();
    return tick_of($urandom_range(0, 1) == 1, CountW'($urandom_range(0, 4095)),
                   9'($urandom_range(0, 511)));
  endfunction

  // discharge sense held open so start-up never completes
  function automatic req_t startup_noise();
    req_t r;
    r = tick_of($urandom_range(0, 9) != 0, pick_counts(), 9'($urandom_range(0, 511)));
    r.common_closed = $urandom_range(0, 4) != 0;
    r.discharge_closed = 1'b0;
    r.battery_in_range = $urandom_range(0, 6) != 0;
    return r;
  endfunction

  function automatic req_t running_tick();
    int pick;
    req_t r;
    r = tick_of($urandom_range(0, 9) != 0, pick_counts(), 9'($urandom_range(0, 511)));
    r.common_closed = 1'b1;
    r.charge_closed = 1'b1;
    r.discharge_closed = 1'b1;
    r.shutdown_request = 1'b0;
    pick = $urandom_range(0, 999);
    if (pick < 25) begin
      r.charge_closed = 1'b0;
      r.charge_override = $urandom_range(0, 9) != 0;
    end else if (pick < 50) begin
      r.discharge_closed = 1'b0;
      r.discharge_override = $urandom_range(0, 9) != 0;
    end else if (pick < 53) begin
      r.common_closed = 1'b0;
      r.charge_closed = 1'b0;
      r.charge_allowed = 1'b1;
      r.charge_override = 1'b1;
    end else if (pick < 56) begin
      r.shutdown_request = 1'b1;
    end
    return r;
  endfunction

  task automatic put_payload(input req_t r);
    {in_current_valid, in_current_counts, in_common_closed, in_charge_closed,
     in_discharge_closed, in_battery_in_range, in_shutdown_request, in_charge_allowed,
     in_discharge_allowed, in_charge_override, in_discharge_override} <= r;
  endtask

  task automatic send_tick(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    put_payload(r);
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic settle(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic set_limits(input logic [CountW-1:0] narrow, input logic [CountW-1:0] wide);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_NARROW;
    cfg_data <= narrow;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_WIDE;
    cfg_data <= wide;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    narrow_lim = narrow;
    wide_lim = wide;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    put_payload('0);
    cfg_valid <= 1'b0;
    cfg_index <= CFG_NARROW;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset limits 77 / 232, walk the pre-start-up phases
    send_tick(tick_of(1'b0, 12'd0, 9'b0_0_0_0_0_0_0_0_0));
    send_tick(tick_of(1'b0, 12'd0, 9'b0_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b0, 12'd0, 9'b0_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd78, 9'b0_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd77, 9'b0_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b0_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd4095, 9'b1_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd77, 9'b1_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd233, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b0, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd232, 9'b1_1_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_0_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_0_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_1_1_1_1_1));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_0_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_1_1_1_1_1));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_1_1_1_1_1));
    send_tick(tick_of(1'b1, 12'd0, 9'b0_1_0_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd4095, 9'b1_1_0_0_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_0_0_0_0_0));

    for (int e = 0; e < 4; e++) begin
      settle(4);
      case (e)
        0: set_limits('0, '0);
        1: set_limits('1, '1);
        2: set_limits(CountW'($urandom_range(0, 4095)), CountW'($urandom_range(0, 4095)));
        default: set_limits('1, '0);
      endcase
      repeat (200) send_tick(startup_noise());
    end

    // full start-up, then recloses on override
    settle(4);
    set_limits(CountW'($urandom_range(0, 4095)), CountW'($urandom_range(0, 4095)));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_0_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_0_1_1_0_1_0_1_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_0_1_0_0_1_0_1));
    send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_0_0_0_0_0));
    repeat (150) send_tick(running_tick());
    settle(4);
    set_limits('0, '1);
    repeat (150) send_tick(running_tick());

    // common lost while an override reclose is asked, or a shutdown
    if ($urandom_range(0, 1) == 1)
      send_tick(tick_of(1'b1, 12'd0, 9'b0_0_1_1_0_1_0_1_0));
    else
      send_tick(tick_of(1'b1, 12'd0, 9'b1_1_1_1_1_0_0_0_0));
    repeat (60) send_tick(noise_tick());

    settle(20);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
